// ----- rtl/core/rth_pkg.sv -----
// Shared types and constants for the RGB to HSV converter.
package rth_pkg;

  // Register stages ahead of the divider pipelines (sort, then numerators).
  localparam int unsigned PreStages = 2;

  // Sector of the largest component, with green winning ties, then blue.
  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

endpackage

// ----- rtl/core/rth_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
module rth_div #(
  parameter int unsigned DW = 8,   // numerator and denominator width
  parameter int unsigned QW = 17   // quotient bits, one per stage
) (
  input  logic          clk_i,
  input  logic          en_i,      // advance all stages
  input  logic [DW-1:0] num_i,     // must satisfy num <= den
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o      // floor(num * 2^(QW-1) / den)
);

  // Partial remainders and divisors travel with the partial quotient
  logic [DW-1:0] rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW-1:0] diff;
    logic [DW-1:0] den_src;
    logic [QW-1:0] quo_src;
    logic          ge;

    // First stage compares the numerator as is, later ones shift in a zero
    if (k == 0) begin : g_first
      assign trial   = {1'b0, num_i};
      assign den_src = den_i;
      assign quo_src = '0;
    end else begin : g_next
      assign trial   = {rem_q[k-1], 1'b0};
      assign den_src = den_q[k-1];
      assign quo_src = quo_q[k-1];
    end

    // Difference only matters when trial >= den, and then it is below den
    assign diff = trial[DW-1:0] - den_src;
    assign ge   = (trial >= {1'b0, den_src});

    // Quotient bit in at the bottom
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_src[QW-2:0], ge};
      end
    end

    // Remainder stays below the divisor, so DW bits hold it
    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff : trial[DW-1:0];
          den_q[k] <= den_src;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ----- rtl/core/rgb_to_hsv.sv -----
// RGB to HSV converter: sort stage, numerator stage, two bit-per-stage dividers.
// Throughput: one pixel per clock unless the output stalls; the depth is set by the
// two dividers, which retire one quotient bit per stage over FRACTION_BITS + 1 stages.
// The whole pipeline holds while an output beat waits for tready.
// Reset (rst_ni low, asynchronous) clears the valid bits; the data path is not reset.
module rgb_to_hsv #(
  parameter int unsigned COMPONENT_BITS = 8,
  parameter int unsigned FRACTION_BITS  = 16,
  localparam int unsigned InW  = ((3 * COMPONENT_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((2 * FRACTION_BITS + 1 + COMPONENT_BITS + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // slave side
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // red, green, blue (lowest bits first)
  // master side
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // hue, saturation, value (lowest bits first)
);

  import rth_pkg::*;

  localparam int unsigned C   = COMPONENT_BITS;
  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned QW  = F + 1;
  localparam int unsigned HW  = C + 3;
  localparam int unsigned NSt = PreStages + QW;

  logic           adv;
  logic [NSt-1:0] v_q;

  logic [C-1:0] in_red, in_green, in_blue;

  // Whole pipeline moves unless a finished beat is held at the output
  assign adv           = ~v_q[NSt-1] | m_axis_tready;
  assign s_axis_tready = adv;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSt-2:0], s_axis_tvalid};
    end
  end

  assign in_red   = s_axis_tdata[C-1:0];
  assign in_green = s_axis_tdata[2*C-1:C];
  assign in_blue  = s_axis_tdata[3*C-1:2*C];

  // Stage A: largest, smallest and sector
  logic [C-1:0] a_red_q, a_green_q, a_blue_q, a_max_q, a_min_q;
  sector_e      a_sec_q;
  logic [C-1:0] a_max_d, a_min_d;
  sector_e      a_sec_d;

  always_comb begin
    if (in_green >= in_red && in_green >= in_blue) begin
      a_sec_d = SecGreen;
      a_max_d = in_green;
    end else if (in_blue >= in_red) begin
      a_sec_d = SecBlue;
      a_max_d = in_blue;
    end else begin
      a_sec_d = SecRed;
      a_max_d = in_red;
    end
    a_min_d = in_red;
    if (in_green < a_min_d) a_min_d = in_green;
    if (in_blue < a_min_d) a_min_d = in_blue;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_red_q   <= in_red;
      a_green_q <= in_green;
      a_blue_q  <= in_blue;
      a_max_q   <= a_max_d;
      a_min_q   <= a_min_d;
      a_sec_q   <= a_sec_d;
    end
  end

  // Stage B: delta, hue numerator and denominator 6*delta
  logic [C-1:0]  b_delta_q, b_max_q;
  logic [HW-1:0] b_num_q, b_den_q;
  logic          b_zero_q;
  logic [C-1:0]  b_delta_d;
  logic [HW-1:0] d3, b_den_d, b_num_d, r3, g3, bl3;

  assign b_delta_d = a_max_q - a_min_q;
  assign d3        = HW'(b_delta_d);
  assign b_den_d   = (d3 << 2) + (d3 << 1);
  assign r3        = HW'(a_red_q);
  assign g3        = HW'(a_green_q);
  assign bl3       = HW'(a_blue_q);

  // Modular sums; the true result is in [0, 6*delta) whenever delta is nonzero
  always_comb begin
    case (a_sec_q)
      SecGreen: b_num_d = (d3 << 1) + bl3 - r3;
      SecBlue:  b_num_d = (d3 << 2) + r3 - g3;
      SecRed:   b_num_d = (a_green_q >= a_blue_q) ? (g3 - bl3) : (b_den_d + g3 - bl3);
      default:  b_num_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_delta_q <= b_delta_d;
      b_max_q   <= a_max_q;
      b_num_q   <= b_num_d;
      b_den_q   <= b_den_d;
      b_zero_q  <= (b_delta_d == '0);
    end
  end

  // Dividers
  logic [QW-1:0] hue_quo, sat_quo;

  rth_div #(.DW(HW), .QW(QW)) u_hue_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (b_num_q),
    .den_i (b_den_q),
    .quo_o (hue_quo)
  );

  rth_div #(.DW(C), .QW(QW)) u_sat_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (b_delta_q),
    .den_i (b_max_q),
    .quo_o (sat_quo)
  );

  // Value and grey flag ride alongside the dividers
  logic [C-1:0] p_max_q  [QW];
  logic         p_zero_q [QW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_max_q[0]  <= b_max_q;
      p_zero_q[0] <= b_zero_q;
      for (int unsigned i = 1; i < QW; i++) begin
        p_max_q[i]  <= p_max_q[i-1];
        p_zero_q[i] <= p_zero_q[i-1];
      end
    end
  end

  // Output beat; grey and black pixels force hue and saturation to zero
  logic [F-1:0] out_hue;
  logic [F:0]   out_sat;
  logic [C-1:0] out_val;

  assign out_hue       = p_zero_q[QW-1] ? '0 : hue_quo[F-1:0];
  assign out_sat       = p_zero_q[QW-1] ? '0 : sat_quo;
  assign out_val       = p_max_q[QW-1];
  assign m_axis_tvalid = v_q[NSt-1];
  assign m_axis_tdata  = OutW'({out_val, out_sat, out_hue});

  // Saturation never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_sat <= (QW'(1) << F))
    else $error("saturation above full scale");

  // A saturated color cannot come from a black pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_sat != '0) |-> (out_val != '0))
    else $error("nonzero saturation with zero value");

  // An accepted beat enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_q[0])
    else $error("accepted beat lost at pipeline entry");

  // Hue quotient stays within one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !p_zero_q[QW-1] |-> !hue_quo[F])
    else $error("hue quotient overflow");

endmodule

// ----- verif/rgb_to_hsv_tb.sv -----
// Self-checking stream testbench for the RGB to HSV pixel converter.
`timescale 1ns / 100ps

module rgb_to_hsv_tb;
  import rth_pkg::*;

  localparam int unsigned CompW      = 8;
  localparam int unsigned FracW      = 16;
  localparam int unsigned PixW       = 24;
  localparam int unsigned HsvW       = 48;
  localparam int unsigned SatLsb     = FracW;
  localparam int unsigned ValLsb     = 2 * FracW + 1;
  localparam int unsigned PhaseBeats = 460;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned DrainWait  = FracW + 3 + 20;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [FracW-1:0] hue;
    logic [FracW:0]   saturation;
    logic [CompW-1:0] value;
  } hsv_t;

  // pacing of both stream sides
  typedef enum logic [1:0] {
    PaceFree,
    PaceSrcIdle,
    PaceSinkStall,
    PaceBothIdle
  } pace_e;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [PixW-1:0] s_axis_tdata;   // red, green, blue
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [HsvW-1:0] m_axis_tdata;   // hue, saturation, value

  logic [PixW-1:0] pixel_q[$];
  hsv_t            hsv_q[$];
  pace_e           pace;
  bit              pix_taken;
  bit              hold_req;
  int unsigned     hold_left;
  int unsigned     cycle_cnt;
  int unsigned     pix_cnt;
  int unsigned     hsv_cnt;
  int unsigned     fail_cnt;

  rgb_to_hsv u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // expected HSV of one pixel, exact fixed point
  function automatic hsv_t rgb_hsv(logic [PixW-1:0] px);
    logic [CompW-1:0]  r, g, b, mx, mn;
    longint unsigned   d, num, den;
    sector_e           sec;
    hsv_t              res;
    r = px[CompW-1:0];
    g = px[2*CompW-1:CompW];
    b = px[3*CompW-1:2*CompW];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = longint'(mx) - longint'(mn);
    res.value = mx;
    res.hue = '0;
    res.saturation = '0;
    if (mx != 0 && d != 0) begin
      res.saturation = (FracW+1)'((d << FracW) / longint'(mx));
      den = 6 * d;
      if (g == mx) sec = SecGreen;
      else if (b == mx) sec = SecBlue;
      else sec = SecRed;
      case (sec)
        SecGreen: num = 2 * d + longint'(b) - longint'(r);
        SecBlue:  num = 4 * d + longint'(r) - longint'(g);
        default: begin
          if (g >= b) num = longint'(g) - longint'(b);
          else num = den - (longint'(b) - longint'(g));
        end
      endcase
      res.hue = FracW'((num << FracW) / den);
    end
    return res;
  endfunction

  function automatic logic [PixW-1:0] rgb(int unsigned r, int unsigned g, int unsigned b);
    return {b[CompW-1:0], g[CompW-1:0], r[CompW-1:0]};
  endfunction

  // random pixel, biased toward greys, tied maxima and tiny values
  function automatic logic [PixW-1:0] rand_pixel();
    int unsigned r, g, b;
    r = $urandom_range(255);
    g = $urandom_range(255);
    b = $urandom_range(255);
    case ($urandom_range(9))
      0: begin
        g = r;
        b = r;
      end
      1: g = r;
      2: b = g;
      3: r = b;
      4: begin
        r = $urandom_range(3);
        g = $urandom_range(3);
        b = $urandom_range(3);
      end
      5: r = 255;
      default: ;
    endcase
    return rgb(r, g, b);
  endfunction

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // pixel driver: holds a beat until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || pix_taken)) begin
      pix_taken = 1'b0;
      if (pixel_q.size() != 0 &&
          !roll((pace == PaceSrcIdle) ? 75 : (pace == PaceBothIdle) ? 6 : 0)) begin
        s_axis_tdata  <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && hold_left == 0 &&
                     !roll((pace == PaceSinkStall) ? 75 : (pace == PaceBothIdle) ? 6 : 0);
  end

  // hold-off counter
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HoldLen;
      hold_req  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // input acceptance: record the expected HSV of each taken pixel
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      hsv_q.push_back(rgb_hsv(s_axis_tdata));
      pix_taken = 1'b1;
      pix_cnt++;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    hsv_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hue        = m_axis_tdata[FracW-1:0];
      got.saturation = m_axis_tdata[SatLsb +: FracW+1];
      got.value      = m_axis_tdata[ValLsb +: CompW];
      hsv_cnt++;
      if (hsv_q.size() == 0) begin
        $error("unexpected output beat: hue %0d saturation %0d value %0d",
               got.hue, got.saturation, got.value);
        fail_cnt++;
      end else begin
        want = hsv_q.pop_front();
        if (got.hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, got.hue);
          fail_cnt++;
        end
        if (got.saturation !== want.saturation) begin
          $error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
          fail_cnt++;
        end
        if (got.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, got.value);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, hsv_q.size());
      $display("** rgb_to_hsv: FAILED **");
      $finish;
    end
  end

  // wait until the driver has handed off every queued pixel
  task automatic wait_sent();
    while (pixel_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
  endtask

  task automatic run_phase(pace_e mode, bit with_hold);
    @(negedge clk_i);
    pace = mode;
    if (with_hold) hold_req = 1'b1;
    repeat (PhaseBeats) pixel_q.push_back(rand_pixel());
    wait_sent();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    pace          = PaceFree;
    pix_taken     = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    cycle_cnt     = 0;
    pix_cnt       = 0;
    hsv_cnt       = 0;
    fail_cnt      = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners: black, greys, primaries, tied maxima, hue wrap
    pixel_q.push_back(rgb(0, 0, 0));
    pixel_q.push_back(rgb(255, 255, 255));
    pixel_q.push_back(rgb(128, 128, 128));
    pixel_q.push_back(rgb(1, 1, 1));
    pixel_q.push_back(rgb(255, 0, 0));
    pixel_q.push_back(rgb(0, 255, 0));
    pixel_q.push_back(rgb(0, 0, 255));
    pixel_q.push_back(rgb(255, 10, 10));
    pixel_q.push_back(rgb(255, 5, 0));
    pixel_q.push_back(rgb(255, 0, 5));
    pixel_q.push_back(rgb(255, 255, 0));
    pixel_q.push_back(rgb(0, 255, 255));
    pixel_q.push_back(rgb(255, 0, 255));
    pixel_q.push_back(rgb(200, 100, 50));
    pixel_q.push_back(rgb(50, 200, 100));
    pixel_q.push_back(rgb(100, 50, 200));
    pixel_q.push_back(rgb(1, 0, 0));
    pixel_q.push_back(rgb(0, 0, 1));
    pixel_q.push_back(rgb(254, 1, 0));
    pixel_q.push_back(rgb(8'hAA, 8'h55, 8'hAA));
    pixel_q.push_back(rgb(8'h55, 8'hAA, 8'h55));
    pixel_q.push_back(rgb(255, 254, 255));
    wait_sent();

    // random pixels; the free-running phase also carries the long hold-off
    run_phase(PaceFree, 1'b1);
    run_phase(PaceSrcIdle, 1'b0);
    run_phase(PaceSinkStall, 1'b0);
    run_phase(PaceBothIdle, 1'b0);

    while (hsv_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d pixels converted and %0d results checked over four pacing modes,",
             pix_cnt, hsv_cnt);
    $display("including greys, tied maxima, hue wrap and a %0d-cycle output hold-off.",
             HoldLen);
    if (fail_cnt == 0) begin
      $display("** rgb_to_hsv: PASSED **");
    end else begin
      $display("** rgb_to_hsv: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rth_pkg.sv
rtl/core/rth_div.sv
rtl/core/rgb_to_hsv.sv
verif/rgb_to_hsv_tb.sv
